>>> rtl/core/pose_correction_decider_defines.svh
// Assertion helpers shared by the RTL.
`ifndef POSE_CORRECTION_DECIDER_DEFINES_SVH
`define POSE_CORRECTION_DECIDER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PCD_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pcd_pkg.sv
package pcd_pkg;

    localparam int MaxStages = 24;
    localparam int DiffW     = 25;
    localparam int DistW     = 25;
    localparam int AngW      = 16;
    // datapath: 25 bit diff << 6, plus CORDIC growth
    localparam int CrdW      = 34;
    localparam logic [31:0] KinvQ30 = 32'd652032874;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_CW     = 3'd1;
    localparam logic [2:0] ACT_CCW    = 3'd2;
    localparam logic [2:0] ACT_DRIVE  = 3'd3;
    localparam logic [2:0] ACT_ACCEPT = 3'd4;

    localparam logic [1:0] MODE_FULL    = 2'd0;
    localparam logic [1:0] MODE_HEADING = 2'd1;
    localparam logic [1:0] MODE_STRICT  = 2'd2;

    localparam logic [2:0] REG_REJECT = 3'd0;
    localparam logic [2:0] REG_STRICT = 3'd1;
    localparam logic [2:0] REG_EXIT   = 3'd2;
    localparam logic [2:0] REG_FINAL  = 3'd3;
    localparam logic [2:0] REG_HTOL   = 3'd4;
    localparam logic [2:0] REG_TURN   = 3'd5;
    localparam logic [2:0] REG_DRIVE  = 3'd6;

    typedef struct packed {
        logic [DistW-1:0] reject_distance;
        logic [DistW-1:0] strict_tolerance;
        logic [DistW-1:0] position_exit;
        logic [DistW-1:0] final_position_limit;
        logic [AngW-1:0]  heading_tolerance;
        logic [AngW-1:0]  turn_limit;
        logic [DistW-1:0] drive_limit;
    } cfg_t;

    // fields carried alongside the CORDIC
    typedef struct packed {
        logic [AngW-1:0] actual_heading;
        logic [AngW-1:0] arrival_heading;
        logic [1:0]      mode;
        logic            zero_vec;
    } side_t;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'd536870912;
            1:  t = 32'd316933406;
            2:  t = 32'd167458907;
            3:  t = 32'd85004756;
            4:  t = 32'd42667331;
            5:  t = 32'd21354465;
            6:  t = 32'd10679838;
            7:  t = 32'd5340245;
            8:  t = 32'd2670163;
            9:  t = 32'd1335087;
            10: t = 32'd667544;
            11: t = 32'd333772;
            12: t = 32'd166886;
            13: t = 32'd83443;
            14: t = 32'd41722;
            15: t = 32'd20861;
            16: t = 32'd10430;
            17: t = 32'd5215;
            18: t = 32'd2608;
            19: t = 32'd1304;
            20: t = 32'd652;
            21: t = 32'd326;
            22: t = 32'd163;
            23: t = 32'd81;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/core/pcd_cfg_regs.sv
module pcd_cfg_regs
    import pcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reject_distance      <= 25'd8000;
            cfg_reg.strict_tolerance     <= 25'd160;
            cfg_reg.position_exit        <= 25'd320;
            cfg_reg.final_position_limit <= 25'd640;
            cfg_reg.heading_tolerance    <= 16'd364;
            cfg_reg.turn_limit           <= 16'd16384;
            cfg_reg.drive_limit          <= 25'd3200;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_REJECT: cfg_reg.reject_distance      <= pwdata[DistW-1:0];
                REG_STRICT: cfg_reg.strict_tolerance     <= pwdata[DistW-1:0];
                REG_EXIT:   cfg_reg.position_exit        <= pwdata[DistW-1:0];
                REG_FINAL:  cfg_reg.final_position_limit <= pwdata[DistW-1:0];
                REG_HTOL:   cfg_reg.heading_tolerance    <= pwdata[AngW-1:0];
                REG_TURN:   cfg_reg.turn_limit           <= pwdata[AngW-1:0];
                REG_DRIVE:  cfg_reg.drive_limit          <= pwdata[DistW-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_REJECT: prdata = {7'd0, cfg_reg.reject_distance};
            REG_STRICT: prdata = {7'd0, cfg_reg.strict_tolerance};
            REG_EXIT:   prdata = {7'd0, cfg_reg.position_exit};
            REG_FINAL:  prdata = {7'd0, cfg_reg.final_position_limit};
            REG_HTOL:   prdata = {16'd0, cfg_reg.heading_tolerance};
            REG_TURN:   prdata = {16'd0, cfg_reg.turn_limit};
            REG_DRIVE:  prdata = {7'd0, cfg_reg.drive_limit};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/core/pcd_cordic.sv
// Vectoring CORDIC: one micro-rotation per register stage, plus an entry stage
// and a three-stage gain multiply. All stages advance on en.
module pcd_cordic
    import pcd_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [DiffW-1:0] dx,
    input  logic signed [DiffW-1:0] dz,
    input  side_t                   in_side,
    output logic                    out_valid,
    output logic [DistW-1:0]        distance,
    output logic [AngW-1:0]         bearing,
    output side_t                   out_side
);

    localparam int N = (STAGES > MaxStages) ? MaxStages : STAGES;

    logic                   v_reg    [0:N];
    logic signed [CrdW-1:0] x_reg    [0:N];
    logic signed [CrdW-1:0] z_reg    [0:N];
    logic [31:0]            acc_reg  [0:N];
    side_t                  side_reg [0:N];

    logic signed [CrdW-1:0] x0, z0;

    assign x0 = CrdW'(dx) <<< 6;
    assign z0 = CrdW'(dz) <<< 6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            if (dx[DiffW-1])
            begin
                x_reg[0]   <= -x0;
                z_reg[0]   <= -z0;
                acc_reg[0] <= 32'h8000_0000;
            end
            else
            begin
                x_reg[0]   <= x0;
                z_reg[0]   <= z0;
                acc_reg[0] <= 32'd0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [CrdW-1:0] xs, zs;
        assign xs = x_reg[i] >>> i;
        assign zs = z_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                if (!z_reg[i][CrdW-1])
                begin
                    x_reg[i+1]   <= x_reg[i] + zs;
                    z_reg[i+1]   <= z_reg[i] - xs;
                    acc_reg[i+1] <= acc_reg[i] + atan_entry(i);
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] - zs;
                    z_reg[i+1]   <= z_reg[i] + xs;
                    acc_reg[i+1] <= acc_reg[i] - atan_entry(i);
                end
            end
        end
    end

    // gain correction: split 33x32 into two partial products
    logic        m1_v_reg, m2_v_reg;
    logic [49:0] plo_reg;
    logic [49:0] phi_reg;
    logic [15:0] brg1_reg, brg2_reg;
    side_t       s1_reg, s2_reg;
    logic [CrdW-2:0] xpos;
    logic [65:0] prod;
    logic [29:0] pr;
    logic [29:0] pr_reg;

    assign xpos = x_reg[N][CrdW-1] ? '0 : x_reg[N][CrdW-2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_v_reg <= v_reg[N];
            m2_v_reg <= m1_v_reg;
        end
    end

    always_comb
    begin
        prod = 66'(plo_reg) + (66'(phi_reg) << 17) + (66'd1 << 35);
        pr   = prod[65:36];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg  <= 50'(xpos[16:0]) * 50'(KinvQ30);
            phi_reg  <= 50'(xpos[32:17]) * 50'(KinvQ30);
            brg1_reg <= 16'((acc_reg[N] + 32'h8000) >> 16);
            s1_reg   <= side_reg[N];
            pr_reg   <= pr;
            brg2_reg <= brg1_reg;
            s2_reg   <= s1_reg;
        end
    end

    logic [DistW-1:0] dist_reg;
    logic [AngW-1:0]  brg_reg;
    side_t            so_reg;
    logic             ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= m2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            so_reg <= s2_reg;
            if (s2_reg.zero_vec)
            begin
                dist_reg <= '0;
                brg_reg  <= '0;
            end
            else
            begin
                dist_reg <= (pr_reg[29:DistW] != '0) ? {DistW{1'b1}} : pr_reg[DistW-1:0];
                brg_reg  <= brg2_reg;
            end
        end
    end

    assign out_valid = ov_reg;
    assign distance  = dist_reg;
    assign bearing   = brg_reg;
    assign out_side  = so_reg;

endmodule

>>> rtl/core/pcd_decide.sv
// Two register stages: wrap errors and compare, then select the step.
module pcd_decide
    import pcd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  logic [DistW-1:0] distance,
    input  logic [AngW-1:0]  bearing,
    input  side_t            side,
    output logic             out_valid,
    output logic [2:0]       action,
    output logic [DistW-1:0] magnitude,
    output logic [DistW-1:0] position_error,
    output logic [AngW-1:0]  target_bearing,
    output logic [AngW-1:0]  bearing_error,
    output logic [AngW-1:0]  arrival_error
);

    logic [AngW-1:0] berr, aerr;
    logic [AngW:0]   babs, aabs;

    assign berr = bearing - side.actual_heading;
    assign aerr = side.arrival_heading - side.actual_heading;
    assign babs = berr[AngW-1] ? (AngW+1)'(-{1'b1, berr}) : {1'b0, berr};
    assign aabs = aerr[AngW-1] ? (AngW+1)'(-{1'b1, aerr}) : {1'b0, aerr};

    logic             v1_reg;
    logic             rej_reg, far_reg, fin_reg, bturn_reg, aturn_reg;
    logic             bcap_reg, acap_reg, dcap_reg;
    logic [1:0]       mode_reg;
    logic [DistW-1:0] dist_reg;
    logic [AngW-1:0]  brg_reg, berr_reg, aerr_reg;
    logic [AngW:0]    babs_reg, aabs_reg;
    logic [DistW-1:0] exit_tol;

    assign exit_tol = (side.mode == MODE_STRICT) ? cfg.strict_tolerance : cfg.position_exit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rej_reg   <= distance > cfg.reject_distance;
            far_reg   <= distance > exit_tol;
            fin_reg   <= distance > cfg.final_position_limit;
            bturn_reg <= babs > {1'b0, cfg.heading_tolerance};
            aturn_reg <= aabs > {1'b0, cfg.heading_tolerance};
            bcap_reg  <= babs > {1'b0, cfg.turn_limit};
            acap_reg  <= aabs > {1'b0, cfg.turn_limit};
            dcap_reg  <= distance > cfg.drive_limit;
            mode_reg  <= side.mode;
            dist_reg  <= distance;
            brg_reg   <= bearing;
            berr_reg  <= berr;
            aerr_reg  <= aerr;
            babs_reg  <= babs;
            aabs_reg  <= aabs;
        end
    end

    logic [2:0]       act;
    logic [DistW-1:0] mag;

    always_comb
    begin
        act = ACT_ACCEPT;
        mag = '0;
        if (rej_reg)
            act = ACT_NONE;
        else if (mode_reg != MODE_HEADING && far_reg)
        begin
            if (bturn_reg)
            begin
                act = berr_reg[AngW-1] ? ACT_CW : ACT_CCW;
                mag = DistW'(bcap_reg ? {1'b0, cfg.turn_limit} : babs_reg);
            end
            else
            begin
                act = ACT_DRIVE;
                mag = dcap_reg ? cfg.drive_limit : dist_reg;
            end
        end
        else if (mode_reg == MODE_HEADING && fin_reg)
            act = ACT_NONE;
        else if (aturn_reg)
        begin
            act = aerr_reg[AngW-1] ? ACT_CW : ACT_CCW;
            mag = DistW'(acap_reg ? {1'b0, cfg.turn_limit} : aabs_reg);
        end
    end

    logic             v2_reg;
    logic [2:0]       act_reg;
    logic [DistW-1:0] mag_reg, pe_reg;
    logic [AngW-1:0]  tb_reg, be_reg, ae_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_reg <= act;
            mag_reg <= mag;
            pe_reg  <= dist_reg;
            tb_reg  <= rej_reg ? '0 : brg_reg;
            be_reg  <= rej_reg ? '0 : berr_reg;
            ae_reg  <= rej_reg ? '0 : aerr_reg;
        end
    end

    assign out_valid      = v2_reg;
    assign action         = act_reg;
    assign magnitude      = mag_reg;
    assign position_error = pe_reg;
    assign target_bearing = tb_reg;
    assign bearing_error  = be_reg;
    assign arrival_error  = ae_reg;

endmodule

>>> rtl/core/pose_correction_decider.sv
// Pose correction decider. Accepts one pose item per clock and returns one
// result item per input, via a subtract stage, the CORDIC entry stage, one
// stage per CORDIC micro-rotation (CORDIC_STAGES, capped at 24), three stages
// for the distance gain multiply, and two decision stages. The whole pipeline
// is stalled while the output holds an item that is not taken. Registers are to
// be written through the APB port only while idle; the block does not enforce it.
`include "pose_correction_decider_defines.svh"
module pose_correction_decider
    import pcd_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // actual_x[23:0], actual_z[47:24], actual_heading[63:48], target_x[87:64],
    // target_z[111:88], arrival_heading[127:112], mode[129:128], zero pad
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // action[2:0], magnitude[27:3], position_error[52:28], target_bearing[68:53],
    // bearing_error[84:69], arrival_error[100:85], zero pad
    output logic [103:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t cfg;
    logic en;

    pcd_cfg_regs u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .cfg(cfg)
    );

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic                    d_v_reg;
    logic signed [DiffW-1:0] dx_reg, dz_reg;
    side_t                   d_side_reg;
    logic signed [DiffW-1:0] dx_n, dz_n;

    assign dx_n = DiffW'($signed(s_tdata[87:64])) - DiffW'($signed(s_tdata[23:0]));
    assign dz_n = DiffW'($signed(s_tdata[111:88])) - DiffW'($signed(s_tdata[47:24]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (en)
            d_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg                     <= dx_n;
            dz_reg                     <= dz_n;
            d_side_reg.actual_heading  <= s_tdata[63:48];
            d_side_reg.arrival_heading <= s_tdata[127:112];
            d_side_reg.mode            <= (s_tdata[129:128] == 2'd3) ? MODE_FULL
                                                                   : s_tdata[129:128];
            d_side_reg.zero_vec        <= (dx_n == '0) && (dz_n == '0);
        end
    end

    logic             c_v;
    logic [DistW-1:0] c_dist;
    logic [AngW-1:0]  c_brg;
    side_t            c_side;

    pcd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk, .rst_n, .en,
        .in_valid(d_v_reg), .dx(dx_reg), .dz(dz_reg), .in_side(d_side_reg),
        .out_valid(c_v), .distance(c_dist), .bearing(c_brg), .out_side(c_side)
    );

    logic [2:0]       action;
    logic [DistW-1:0] magnitude, position_error;
    logic [AngW-1:0]  target_bearing, bearing_error, arrival_error;

    pcd_decide u_decide (
        .clk, .rst_n, .en, .cfg,
        .in_valid(c_v), .distance(c_dist), .bearing(c_brg), .side(c_side),
        .out_valid(m_tvalid), .action, .magnitude, .position_error,
        .target_bearing, .bearing_error, .arrival_error
    );

    assign m_tdata = {3'd0, arrival_error, bearing_error, target_bearing,
                      position_error, magnitude, action};

    `PCD_ASSERT(a_stall_holds, m_tvalid && !m_tready, !s_tready, "input taken during stall")
    `PCD_ASSERT(a_action_range, m_tvalid, action <= ACT_ACCEPT, "bad action code")
    `PCD_ASSERT(a_accept_zero, m_tvalid && action == ACT_ACCEPT, magnitude == '0, "accept with nonzero magnitude")
    `PCD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")

endmodule
